@@ sv/mvt_pkg.sv @@
`default_nettype none

package mvt_pkg;

  // Parameter defaults
  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Matrix shape: column-major, index = row + 3*col
  localparam int NUM_COEFFS = 9;
  localparam int NUM_ROWS   = 3;

  // Field widths
  localparam int OP_W   = 3;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 32;
  localparam int COMP_W = 32;

  // Stream widths
  localparam int IN_TUSER_W  = OP_W;
  localparam int IN_TDATA_W  = 136;  // 132 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_IDENT = 3'd3;
  localparam logic [OP_W-1:0] OP_XFORM = 3'd4;

  // Matrix update command from the input stage to the coefficient bank
  typedef struct packed {
    logic              wr;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
  } mvt_cmd_t;

endpackage

`default_nettype wire

@@ sv/mvt_sat.sv @@
`default_nettype none

module mvt_sat #(
  parameter int IN_W  = 34,
  parameter int OUT_W = 32
) (
  input  wire logic [IN_W-1:0]  din,
  output logic      [OUT_W-1:0] dout,
  output logic                  clipped
);

  logic [IN_W-OUT_W:0] upper;
  logic                fits;

  // Value fits when all bits from the target sign bit up agree
  assign upper   = din[IN_W-1:OUT_W-1];
  assign fits    = (&upper) || !(|upper);
  assign clipped = !fits;

  always_comb begin
    if (fits) begin
      dout = din[OUT_W-1:0];
    end else if (din[IN_W-1]) begin
      dout = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      dout = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ sv/mvt_coeff_bank.sv @@
`default_nettype none

module mvt_coeff_bank
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mvt_cmd_t              cmd,
  output logic      [WORD_WIDTH-1:0] coeffs [NUM_COEFFS]
);

  localparam int AW = ((WORD_WIDTH > VAL_W) ? WORD_WIDTH : VAL_W) + 2;

  // Unity on the diagonal, clipped when it does not fit the word
  localparam logic [WORD_WIDTH-1:0] UNITY = (FRAC_BITS >= WORD_WIDTH - 1) ?
    {1'b0, {(WORD_WIDTH-1){1'b1}}} : (WORD_WIDTH'(1) << FRAC_BITS);

  logic        [WORD_WIDTH-1:0] coeffs_r   [NUM_COEFFS];
  logic        [WORD_WIDTH-1:0] coeffs_nxt [NUM_COEFFS];
  logic                         idx_ok;
  logic signed [WORD_WIDTH-1:0] cur;
  logic signed [AW-1:0]         cur_ext;
  logic signed [AW-1:0]         val_ext;
  logic signed [AW-1:0]         upd;
  logic        [WORD_WIDTH-1:0] upd_sat;
  logic                         upd_clip;

  // Pick the addressed element; out-of-range indexes leave the matrix alone
  assign idx_ok  = (cmd.idx < IDX_W'(NUM_COEFFS));
  assign cur     = idx_ok ? coeffs_r[cmd.idx] : '0;
  assign cur_ext = AW'(cur);
  assign val_ext = AW'($signed(cmd.value));

  always_comb begin
    case (cmd.op)
      OP_ADD:  upd = cur_ext + val_ext;
      OP_SUB:  upd = cur_ext - val_ext;
      default: upd = val_ext;
    endcase
  end

  mvt_sat #(
    .IN_W  (AW),
    .OUT_W (WORD_WIDTH)
  ) u_sat (
    .din     (upd),
    .dout    (upd_sat),
    .clipped (upd_clip)
  );

  // Apply the command to every element it touches
  always_comb begin
    for (int i = 0; i < NUM_COEFFS; i++) begin
      coeffs_nxt[i] = coeffs_r[i];
      if (cmd.wr) begin
        case (cmd.op)
          OP_LOAD, OP_ADD, OP_SUB: begin
            if (idx_ok && (cmd.idx == IDX_W'(i))) begin
              coeffs_nxt[i] = upd_sat;
            end
          end
          OP_IDENT: begin
            coeffs_nxt[i] = (i == 0 || i == 4 || i == 8) ? UNITY : '0;
          end
          default: begin
            coeffs_nxt[i] = coeffs_r[i];
          end
        endcase
      end
    end
  end

  // Reset to identity
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_COEFFS; i++) begin
      if (!rst_n) begin
        coeffs_r[i] <= (i == 0 || i == 4 || i == 8) ? UNITY : '0;
      end else begin
        coeffs_r[i] <= coeffs_nxt[i];
      end
    end
  end

  assign coeffs = coeffs_r;

endmodule

`default_nettype wire

@@ sv/mvt_row_mac.sv @@
`default_nettype none

module mvt_row_mac
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  load,
  input  wire logic [WORD_WIDTH-1:0] coef [NUM_ROWS],
  input  wire logic [COMP_W-1:0]     vec  [NUM_ROWS],
  output logic      [COMP_W-1:0]     result,
  output logic                       clipped
);

  localparam int PW  = WORD_WIDTH + COMP_W;
  localparam int SW  = PW - FRAC_BITS;
  localparam int SUW = SW + 2;

  logic signed [PW-1:0]         prod     [NUM_ROWS];
  logic signed [SW-1:0]         prod_r   [NUM_ROWS];
  logic signed [SUW-1:0]        row_sum;
  logic        [WORD_WIDTH-1:0] sum_sat;
  logic signed [PW-1:0]         sum_ext;

  // Products, truncated toward minus infinity by dropping fraction bits
  always_comb begin
    for (int k = 0; k < NUM_ROWS; k++) begin
      prod[k] = $signed(coef[k]) * $signed(vec[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        prod_r[k] <= prod[k][PW-1:FRAC_BITS];
      end
    end
  end

  // Exact row sum, then clip to the word
  assign row_sum = SUW'(prod_r[0]) + SUW'(prod_r[1]) + SUW'(prod_r[2]);

  mvt_sat #(
    .IN_W  (SUW),
    .OUT_W (WORD_WIDTH)
  ) u_sat (
    .din     (row_sum),
    .dout    (sum_sat),
    .clipped (clipped)
  );

  // Carry the low component bits of the sign-extended word
  assign sum_ext = PW'($signed(sum_sat));
  assign result  = sum_ext[COMP_W-1:0];

endmodule

`default_nettype wire

@@ sv/matrix3_vector_transform.sv @@
// Q16.16 3x3 matrix times vector engine.
// Input stream (in_*): in_tuser carries the opcode (load, add, subtract,
// identity, transform); in_tdata carries the element index and value and
// the x, y, z vector. Load, add, subtract and identity update the matrix
// held inside and give no result; unknown opcodes and element indexes of
// 9 and up are dropped. A transform gives one result on the output stream
// (out_*): out_tdata holds x, y, z and out_tuser the overflow flag.
// Throughput: one item per cycle, every opcode, while the result side does
// not stall. A transform passes the input register, the product register
// and the output register in turn. Matrix updates take effect in program
// order, so a transform always sees every update sent before it.
// Reset: synchronous, active low; the matrix returns to identity and all
// stages empty.
// Stall: when out_tready is low the result holds and the stages behind it
// fill; in_tready drops only once the input register cannot advance.
`default_nettype none

module matrix3_vector_transform
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // element_index, element_value,
                                                  // vec_x, vec_y, vec_z, pad
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // opcode
  // Result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // out_x, out_y, out_z
  output logic      [OUT_TUSER_W-1:0] out_tuser   // overflow
);

  // Input register
  logic                  s1_v_r;
  logic                  s1_v_nxt;
  logic [OP_W-1:0]       s1_op_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [VAL_W-1:0]      s1_val_r;
  logic [COMP_W-1:0]     s1_vec_r [NUM_ROWS];

  // Product stage and output register
  logic                  s2_v_r;
  logic                  s2_v_nxt;
  logic                  out_v_r;
  logic                  out_v_nxt;
  logic [COMP_W-1:0]     out_comp_r [NUM_ROWS];
  logic                  out_ovf_r;

  logic                  in_xfer;
  logic                  s1_xform;
  logic                  s1_fire;
  logic                  s2_load;
  logic                  s2_rdy;
  logic                  out_rdy;
  logic                  out_load;
  mvt_cmd_t              cmd;
  logic [WORD_WIDTH-1:0] coeffs   [NUM_COEFFS];
  logic [WORD_WIDTH-1:0] row_coef [NUM_ROWS][NUM_ROWS];
  logic [COMP_W-1:0]     row_res  [NUM_ROWS];
  logic [NUM_ROWS-1:0]   row_clip;

  // Flow control: each stage moves when the one after it has room
  assign out_rdy   = !out_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || out_rdy;
  assign s1_xform  = (s1_op_r == OP_XFORM);
  assign s1_fire   = s1_v_r && (!s1_xform || s2_rdy);
  assign in_tready = !s1_v_r || s1_fire;
  assign in_xfer   = in_tvalid && in_tready;
  assign s2_load   = s1_fire && s1_xform;
  assign out_load  = s2_v_r && out_rdy;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (out_rdy) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= in_tuser[OP_W-1:0];
      s1_idx_r    <= in_tdata[3:0];
      s1_val_r    <= in_tdata[35:4];
      s1_vec_r[0] <= in_tdata[67:36];
      s1_vec_r[1] <= in_tdata[99:68];
      s1_vec_r[2] <= in_tdata[131:100];
    end
  end

  // Matrix updates retire from the input register in order
  assign cmd.wr    = s1_fire && !s1_xform;
  assign cmd.op    = s1_op_r;
  assign cmd.idx   = s1_idx_r;
  assign cmd.value = s1_val_r;

  mvt_coeff_bank #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_coeff_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .coeffs (coeffs)
  );

  // Row r uses elements r, r+3, r+6
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        row_coef[r][c] = coeffs[r + NUM_ROWS * c];
      end
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    mvt_row_mac #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_row_mac (
      .clk     (clk),
      .load    (s2_load),
      .coef    (row_coef[r]),
      .vec     (s1_vec_r),
      .result  (row_res[r]),
      .clipped (row_clip[r])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_comp_r <= row_res;
      out_ovf_r  <= |row_clip;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_comp_r[2], out_comp_r[1], out_comp_r[0]};
  assign out_tuser  = out_ovf_r;

endmodule

`default_nettype wire

@@ sv/mvt_checker.sv @@
`default_nettype none

module mvt_checker
  import mvt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic [IN_TUSER_W-1:0]  in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input is never held off while the receiver takes results
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with receiver ready");

  // A transform reaches the output when nothing stalls
  a_xform_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_XFORM && out_tready)
      ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("transform result late");

endmodule

bind matrix3_vector_transform mvt_checker u_mvt_checker (.*);

`default_nettype wire

@@ tb/matrix3_vector_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams of the 3x3 matrix-vector engine. It keeps its own copy
// of the coefficient matrix and predicts each transform result. Every output
// transfer is then compared against the oldest prediction.
module matrix3_vector_checker
  import mvt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int                     mismatch_count,
  output int                     xforms_in_flight
);

  localparam int MAX_REPORTS = 60;

  typedef struct packed {
    logic [COMP_W-1:0] comp_x;
    logic [COMP_W-1:0] comp_y;
    logic [COMP_W-1:0] comp_z;
    logic              overflow;
  } xform_result_t;

  logic signed [VAL_W-1:0] coeffs [NUM_COEFFS];
  xform_result_t           expected_xforms [$];

  initial begin
    mismatch_count   = 0;
    xforms_in_flight = 0;
  end

  // Clamp to a signed 32-bit word; the top bit flags saturation
  function automatic logic [VAL_W:0] clamp_word(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    if (v < -50'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[VAL_W-1:0]};
  endfunction

  task automatic set_identity();
    for (int i = 0; i < NUM_COEFFS; i++) begin
      coeffs[i] = '0;
    end
    coeffs[0] = VAL_W'(1) << FRAC_BITS_DEF;
    coeffs[4] = VAL_W'(1) << FRAC_BITS_DEF;
    coeffs[8] = VAL_W'(1) << FRAC_BITS_DEF;
  endtask

  // Matrix times vector: truncate each product, sum a row exactly, then clamp
  function automatic xform_result_t predict_transform(input logic signed [COMP_W-1:0] vx,
                                                      input logic signed [COMP_W-1:0] vy,
                                                      input logic signed [COMP_W-1:0] vz);
    xform_result_t           res;
    logic signed [COMP_W-1:0] vec  [NUM_ROWS];
    logic signed [COMP_W-1:0] comp [NUM_ROWS];
    logic signed [63:0]      prod;
    logic signed [49:0]      acc;
    logic [VAL_W:0]          clamped;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    res.overflow = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      acc = '0;
      for (int c = 0; c < NUM_ROWS; c++) begin
        prod = coeffs[r + NUM_ROWS * c] * vec[c];
        acc  = acc + (prod >>> FRAC_BITS_DEF);
      end
      clamped = clamp_word(acc);
      comp[r] = clamped[VAL_W-1:0];
      if (clamped[VAL_W]) begin
        res.overflow = 1'b1;
      end
    end
    res.comp_x = comp[0];
    res.comp_y = comp[1];
    res.comp_z = comp[2];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [COMP_W-1:0] got,
                                 input logic [COMP_W-1:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Track accepted commands and compare accepted results
  always @(posedge clk) begin
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  val;
    logic signed [49:0]       wide;
    logic [VAL_W:0]           clamped;
    xform_result_t            want;
    if (!rst_n) begin
      set_identity();
      expected_xforms.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        op  = in_tuser;
        idx = in_tdata[0 +: IDX_W];
        val = in_tdata[IDX_W +: VAL_W];
        case (op)
          OP_LOAD: begin
            if (idx < NUM_COEFFS) begin
              coeffs[idx] = val;
            end
          end
          OP_ADD, OP_SUB: begin
            if (idx < NUM_COEFFS) begin
              wide = coeffs[idx];
              wide = (op == OP_ADD) ? wide + val : wide - val;
              clamped = clamp_word(wide);
              coeffs[idx] = clamped[VAL_W-1:0];
            end
          end
          OP_IDENT: set_identity();
          OP_XFORM: begin
            expected_xforms.push_back(predict_transform(
              in_tdata[IDX_W + VAL_W +: COMP_W],
              in_tdata[IDX_W + VAL_W + COMP_W +: COMP_W],
              in_tdata[IDX_W + VAL_W + 2 * COMP_W +: COMP_W]));
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_xforms.size() == 0) begin
          report_mismatch("unexpected result x", out_tdata[0 +: COMP_W], '0);
        end else begin
          want = expected_xforms.pop_front();
          if (out_tdata[0 +: COMP_W] !== want.comp_x) begin
            report_mismatch("out_x", out_tdata[0 +: COMP_W], want.comp_x);
          end
          if (out_tdata[COMP_W +: COMP_W] !== want.comp_y) begin
            report_mismatch("out_y", out_tdata[COMP_W +: COMP_W], want.comp_y);
          end
          if (out_tdata[2 * COMP_W +: COMP_W] !== want.comp_z) begin
            report_mismatch("out_z", out_tdata[2 * COMP_W +: COMP_W], want.comp_z);
          end
          if (out_tuser[0] !== want.overflow) begin
            report_mismatch("overflow", COMP_W'(out_tuser[0]), COMP_W'(want.overflow));
          end
        end
      end
    end
    xforms_in_flight = expected_xforms.size();
  end

endmodule

@@ tb/matrix3_vector_transform_test.sv @@
`timescale 1ns / 1ps

module matrix3_vector_transform_test;
  import mvt_pkg::*;

  localparam int  RANDOM_ITEMS = 1900;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  IDLE_PCT     = 30;
  localparam logic [COMP_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [COMP_W-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] W_MIN = 32'h8000_0000;
  localparam logic [COMP_W-1:0] W_NEG1 = 32'hFFFF_FFFF;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int mismatch_count;
  int xforms_in_flight;
  int cycle_count = 0;
  bit calm        = 1'b0;

  matrix3_vector_transform uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  matrix3_vector_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .mismatch_count   (mismatch_count),
    .xforms_in_flight (xforms_in_flight)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("matrix3_vector_transform_test: done, errors");
      $finish;
    end
  end

  // Present one command, idling first at random, and hold it until the transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [COMP_W-1:0] x,
                           input logic [COMP_W-1:0] y, input logic [COMP_W-1:0] z);
    bit took;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({z, y, x, val, idx});
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
  endtask

  // Mix of extremes, full-range words and small Q16.16 values
  function automatic logic [COMP_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2, 3: return $urandom();
      4: return COMP_W'($urandom_range(15)) - COMP_W'(8);
      default: return COMP_W'($urandom_range(32'h0008_0000)) - COMP_W'(32'h0004_0000);
    endcase
  endfunction

  initial begin
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    int               roll;
    int               sent;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturation at both ends, ignored commands, truncation
    send_item(OP_XFORM, '0, '0, W_MAX, W_MIN, Q_ONE);
    send_item(OP_LOAD, 4'd0, W_MAX, '0, '0, '0);
    send_item(OP_LOAD, 4'd3, W_MAX, '0, '0, '0);
    send_item(OP_LOAD, 4'd6, W_MAX, '0, '0, '0);
    send_item(OP_XFORM, '0, '0, W_MAX, W_MAX, W_MAX);
    send_item(OP_XFORM, '0, '0, W_MIN, W_MIN, W_MIN);
    send_item(OP_ADD, 4'd0, 32'd1, '0, '0, '0);
    send_item(OP_LOAD, 4'd8, W_MIN, '0, '0, '0);
    send_item(OP_SUB, 4'd8, 32'd1, '0, '0, '0);
    send_item(OP_SUB, 4'd4, W_MIN, '0, '0, '0);
    send_item(OP_ADD, 4'd2, W_MIN, '0, '0, '0);
    send_item(OP_XFORM, '0, '0, W_NEG1, W_NEG1, W_NEG1);
    send_item(OP_LOAD, 4'hF, '0, '0, '0, '0);
    send_item(OP_ADD, IDX_W'(NUM_COEFFS), Q_ONE, '0, '0, '0);
    send_item(OP_SUB, 4'd12, Q_ONE, '0, '0, '0);
    for (int k = OP_XFORM + 1; k < 2 ** OP_W; k++) begin
      send_item(OP_W'(k), 4'hF, W_NEG1, W_NEG1, W_NEG1, W_NEG1);
    end
    send_item(OP_XFORM, '0, '0, Q_ONE, W_NEG1, W_MAX);
    send_item(OP_IDENT, '0, '0, '0, '0, '0);
    send_item(OP_LOAD, 4'd0, 32'h0000_8000, '0, '0, '0);
    send_item(OP_XFORM, '0, '0, W_NEG1, 32'd1, '0);
    send_item(OP_XFORM, '0, '0, '0, '0, '0);

    // Random: mostly transforms and element updates, some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 700 && sent < 1000);
      roll = $urandom_range(99);
      idx  = IDX_W'($urandom_range(NUM_COEFFS - 1));
      if (roll < 45) begin
        op = OP_XFORM;
      end else if (roll < 65) begin
        op = OP_LOAD;
      end else if (roll < 75) begin
        op = OP_ADD;
      end else if (roll < 85) begin
        op = OP_SUB;
      end else if (roll < 88) begin
        op = OP_IDENT;
      end else begin
        op = OP_W'($urandom_range(2 ** OP_W - 1, OP_XFORM + 1));
      end
      if (op <= OP_SUB && $urandom_range(99) < 8) begin
        idx = IDX_W'($urandom_range(2 ** IDX_W - 1, NUM_COEFFS));
      end
      send_item(op, idx, pick_word(), pick_word(), pick_word(), pick_word());
      sent++;
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain outstanding results, then watch a little longer for strays
    while (xforms_in_flight != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && xforms_in_flight == 0) begin
      $display("matrix3_vector_transform_test: done, clean");
    end else begin
      $display("matrix3_vector_transform_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mvt_pkg.sv
sv/mvt_sat.sv
sv/mvt_coeff_bank.sv
sv/mvt_row_mac.sv
sv/matrix3_vector_transform.sv
sv/mvt_checker.sv
tb/matrix3_vector_checker.sv
tb/matrix3_vector_transform_test.sv
